// ----- rtl/bme_pkg.sv -----
// Shared types and constants for the bounded monomial enumerator.
// No dependencies; every other file of the block imports this package.
package bme_pkg;

    localparam int NUM_VARS_DEF  = 8;
    localparam int EXP_WIDTH_DEF = 8;

    // Fixed interface geometry: eight byte lanes on every packed word.
    localparam int LANES      = 8;
    localparam int LANE_W     = 8;
    localparam int WORD_W     = LANES * LANE_W;
    localparam int AV_W       = 4;
    localparam int ORD_W      = 8;
    localparam int DEG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = WORD_W;
    localparam int M_TDATA_W  = ((WORD_W + DEG_W + 7) / 8) * 8;

    localparam logic [AV_W-1:0]   ACTIVE_VARS_RST = AV_W'(8);
    localparam logic [ORD_W-1:0]  ORDER_LIMIT_RST = '1;
    localparam logic [WORD_W-1:0] VAR_LIMITS_RST  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_VARS = 2'd0,
        CFG_ORDER_LIMIT = 2'd1,
        CFG_VAR_LIMITS  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_ADVANCE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Update command from the sequencer to the exponent store.
    typedef struct packed {
        logic load;
        logic writeback;
        logic found;
    } store_cmd_t;

endpackage

// ----- rtl/bme_exp_store.sv -----
// Exponent store: one register per variable lane, loaded in parallel and
// updated after a walk. Depends on bme_pkg.
module bme_exp_store #(
    parameter int NUM_VARS  = bme_pkg::NUM_VARS_DEF,
    parameter int EXP_WIDTH = bme_pkg::EXP_WIDTH_DEF,
    parameter int IDX_W     = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1,
    parameter int CNT_W     = $clog2(NUM_VARS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bme_pkg::store_cmd_t           cmd,
    input  logic [bme_pkg::WORD_W-1:0]    load_word,
    input  logic [IDX_W-1:0]              win_idx,
    input  logic [CNT_W-1:0]              active_n,
    input  logic [IDX_W-1:0]              rd_idx,
    output logic [EXP_WIDTH-1:0]          rd_lane,
    output logic [NUM_VARS*EXP_WIDTH-1:0] lanes
);
    import bme_pkg::*;

    logic [EXP_WIDTH-1:0] lane_reg [NUM_VARS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_VARS; j++) begin
                lane_reg[j] <= '0;
            end
        end else if (cmd.load) begin
            for (int j = 0; j < NUM_VARS; j++) begin
                lane_reg[j] <= load_word[LANE_W*j +: EXP_WIDTH];
            end
        end else if (cmd.writeback) begin
            // Lanes below the winner were tried and cleared; without a winner
            // every active lane clears. Inactive lanes keep their values.
            for (int j = 0; j < NUM_VARS; j++) begin
                if (CNT_W'(j) < active_n) begin
                    if (!cmd.found || IDX_W'(j) < win_idx) begin
                        lane_reg[j] <= '0;
                    end else if (IDX_W'(j) == win_idx) begin
                        lane_reg[j] <= lane_reg[j] + EXP_WIDTH'(1);
                    end
                end
            end
        end
    end

    assign rd_lane = lane_reg[rd_idx];

    always_comb begin
        for (int j = 0; j < NUM_VARS; j++) begin
            lanes[EXP_WIDTH*j +: EXP_WIDTH] = lane_reg[j];
        end
    end

endmodule

// ----- rtl/bme_lane_walk.sv -----
// Lane evaluator: takes one exponent per cycle from the highest active lane
// down, keeps the running sum of the lanes above and picks the lowest lane
// whose increment gives a valid monomial. Depends on bme_pkg.
module bme_lane_walk #(
    parameter int NUM_VARS  = bme_pkg::NUM_VARS_DEF,
    parameter int EXP_WIDTH = bme_pkg::EXP_WIDTH_DEF,
    parameter int IDX_W     = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1
) (
    input  logic                        aclk,
    input  logic                        clear,
    input  logic                        step,
    input  logic [IDX_W-1:0]            idx,
    input  logic [EXP_WIDTH-1:0]        lane,
    input  logic [bme_pkg::LANE_W-1:0]  lane_limit,
    input  logic [bme_pkg::ORD_W-1:0]   order_limit,
    output logic                        found,
    output logic [IDX_W-1:0]            win_idx,
    output logic [bme_pkg::DEG_W-1:0]   win_degree,
    output logic [bme_pkg::DEG_W-1:0]   total_degree
);
    import bme_pkg::*;

    localparam int CMP_W = LANE_W + 1;

    logic [DEG_W-1:0] suffix_reg, suffix_next;
    logic             bad_reg;
    logic             found_reg;
    logic [IDX_W-1:0] win_idx_reg;
    logic [DEG_W-1:0] win_deg_reg;

    logic [CMP_W-1:0] lane_x, lane_inc, limit_x;
    logic [DEG_W:0]   cand_deg;
    logic             room, lim_ok, ord_ok, over, cand_ok;

    always_comb begin
        lane_x      = CMP_W'(lane);
        lane_inc    = lane_x + CMP_W'(1);
        limit_x     = CMP_W'(lane_limit);
        room        = (lane != '1);
        lim_ok      = (lane_inc <= limit_x);
        over        = (lane_x > limit_x);
        cand_deg    = (DEG_W+1)'(suffix_reg) + (DEG_W+1)'(lane_inc);
        ord_ok      = (cand_deg <= (DEG_W+1)'(order_limit));
        // Lanes below this one would be zero, lanes above keep their values.
        cand_ok     = room && lim_ok && ord_ok && !bad_reg;
        suffix_next = suffix_reg + DEG_W'(lane);
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            suffix_reg <= '0;
            bad_reg    <= 1'b0;
            found_reg  <= 1'b0;
        end else if (step) begin
            suffix_reg <= suffix_next;
            bad_reg    <= bad_reg | over;
            if (cand_ok) begin
                found_reg   <= 1'b1;
                win_idx_reg <= idx;
                win_deg_reg <= DEG_W'(cand_deg);
            end
        end
    end

    assign found        = found_reg;
    assign win_idx      = win_idx_reg;
    assign win_degree   = found_reg ? win_deg_reg : '0;
    assign total_degree = suffix_reg;

endmodule

// ----- rtl/bounded_monomial_enumerator_unit.sv -----
// Top level of the bounded monomial enumerator: configuration registers,
// sequencer, output register. Depends on bme_pkg, bme_exp_store, bme_lane_walk.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid / s_tready  s_tdata exponents, s_tuser kind
//   m_        out        m_tvalid / m_tready  m_tdata exponents+degree, m_tuser flag
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Every transaction walks the active lanes from the highest down (ST_WALK),
// then passes through an update state (ST_FINISH) and an output state (ST_OUT)
// that loads the output register once it is free; the next one is taken in ST_IDLE.
// A load runs the same walk to form the total degree. A stalled result sits in
// the output register while the next transaction is accepted; that one waits
// after its update state. aresetn is synchronous, clears the exponents and
// restores the configuration defaults.
module bounded_monomial_enumerator_unit #(
    parameter int NUM_VARS  = bme_pkg::NUM_VARS_DEF,
    parameter int EXP_WIDTH = bme_pkg::EXP_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input transaction.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bme_pkg::S_TDATA_W-1:0]       s_tdata,  // [63:0] start_exponents
    input  logic                                s_tuser,  // [0] kind
    // Result transaction.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bme_pkg::M_TDATA_W-1:0]       m_tdata,  // [63:0] exponents,
                                                          // [74:64] total_degree
    output logic                                m_tuser,  // [0] advanced (also set for a load)
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bme_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bme_pkg::*;

    localparam int IDX_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int CNT_W = $clog2(NUM_VARS + 1);

    logic [AV_W-1:0]   active_vars_reg;
    logic [ORD_W-1:0]  order_limit_reg;
    logic [WORD_W-1:0] var_limits_reg;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    kind_t            kind_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic [CNT_W-1:0]              active_n;
    logic                          s_accept, walk_step, out_load;
    store_cmd_t                    cmd;
    logic [EXP_WIDTH-1:0]          rd_lane;
    logic [NUM_VARS*EXP_WIDTH-1:0] lanes;
    logic                          found;
    logic [IDX_W-1:0]              win_idx;
    logic [DEG_W-1:0]              win_degree, total_degree;
    logic [WORD_W-1:0]             exp_word;
    logic [DEG_W-1:0]              deg_out;

    // A count of zero means one variable; counts above the lane count saturate.
    always_comb begin
        if (active_vars_reg == '0) begin
            active_n = CNT_W'(1);
        end else if (active_vars_reg > AV_W'(NUM_VARS)) begin
            active_n = CNT_W'(NUM_VARS);
        end else begin
            active_n = CNT_W'(active_vars_reg);
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_vars_reg <= ACTIVE_VARS_RST;
            order_limit_reg <= ORDER_LIMIT_RST;
            var_limits_reg  <= VAR_LIMITS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ACTIVE_VARS: active_vars_reg <= cfg_data[AV_W-1:0];
                CFG_ORDER_LIMIT: order_limit_reg <= cfg_data[ORD_W-1:0];
                CFG_VAR_LIMITS:  var_limits_reg  <= cfg_data[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        walk_step     = 1'b0;
        out_load      = 1'b0;
        cmd.load      = 1'b0;
        cmd.writeback = 1'b0;
        cmd.found     = found;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd.load   = (kind_t'(s_tuser) == KIND_LOAD);
                    idx_next   = IDX_W'(active_n - CNT_W'(1));
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                walk_step = 1'b1;
                if (idx_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_FINISH: begin
                cmd.writeback = (kind_reg == KIND_ADVANCE);
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (s_accept) begin
            kind_reg <= kind_t'(s_tuser);
        end
    end

    bme_exp_store #(
        .NUM_VARS  (NUM_VARS),
        .EXP_WIDTH (EXP_WIDTH),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .load_word (s_tdata[WORD_W-1:0]),
        .win_idx   (win_idx),
        .active_n  (active_n),
        .rd_idx    (idx_reg),
        .rd_lane   (rd_lane),
        .lanes     (lanes)
    );

    bme_lane_walk #(
        .NUM_VARS  (NUM_VARS),
        .EXP_WIDTH (EXP_WIDTH),
        .IDX_W     (IDX_W)
    ) u_walk (
        .aclk         (aclk),
        .clear        (s_accept),
        .step         (walk_step),
        .idx          (idx_reg),
        .lane         (rd_lane),
        .lane_limit   (var_limits_reg[LANE_W*idx_reg +: LANE_W]),
        .order_limit  (order_limit_reg),
        .found        (found),
        .win_idx      (win_idx),
        .win_degree   (win_degree),
        .total_degree (total_degree)
    );

    // Inactive lanes read as zero on the output.
    always_comb begin
        exp_word = '0;
        for (int j = 0; j < NUM_VARS; j++) begin
            if (CNT_W'(j) < active_n) begin
                exp_word[LANE_W*j +: LANE_W] = LANE_W'(lanes[EXP_WIDTH*j +: EXP_WIDTH]);
            end
        end
        deg_out = (kind_reg == KIND_LOAD) ? total_degree : win_degree;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'({deg_out, exp_word});
            m_tuser_reg <= (kind_reg == KIND_LOAD) || found;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/bme_checker.sv -----
// Port-level checker for the bounded monomial enumerator, bound to the top
// level below. Depends on bme_pkg and bounded_monomial_enumerator_unit.
module bme_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bme_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import bme_pkg::*;

    logic [1:0] pending_reg;

    // Transactions accepted whose results are not yet delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(s_tvalid && s_tready)
                                       - 2'(m_tvalid && m_tready);
        end
    end

    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pending_reg != 2'd0))
        else $error("result shown without an accepted transaction");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a transaction is in progress");

    a_failed_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed advance left nonzero exponents or degree");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind bounded_monomial_enumerator_unit bme_checker u_bme_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
